// ----- rtl/core/dtot_pkg.sv -----
// ============================================================================
// dtot_pkg
// Shared types, register indexes and helpers for the device timestamp
// offset tracker.
// ============================================================================
package dtot_pkg;

    localparam int unsigned US_W   = 32;   // device time, microseconds
    localparam int unsigned HOST_W = 63;   // host time, nanoseconds
    localparam int unsigned NS_W   = 42;   // 32-bit microseconds scaled by 1000
    localparam int unsigned WIDE_W = 64;   // wrapped offset arithmetic
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC_THRSH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_DELAY   = 2'd2;

    // Reset values
    localparam logic [US_W-1:0] HOLD_WINDOW_RST = 32'd0;
    localparam logic [NS_W-1:0] RESYNC_NS_RST   = 42'd100_000_000;  // 100000 us
    localparam logic [NS_W-1:0] LINK_NS_RST     = 42'd0;

    typedef struct packed {
        logic [US_W-1:0]   device_time_us;
        logic [HOST_W-1:0] host_time_ns;
    } t_in_item;

    typedef struct packed {
        logic signed [WIDE_W-1:0] corrected_time_ns;
        logic signed [WIDE_W-1:0] offset_error_ns;
        logic [NS_W-1:0]          device_time_ns;
        logic                     resynced;
    } t_out_item;

    // Configuration, thresholds kept pre-scaled to nanoseconds
    typedef struct packed {
        logic [US_W-1:0] hold_us;
        logic [NS_W-1:0] resync_ns;
        logic [NS_W-1:0] link_ns;
    } t_cfg;

    // Input stage contents
    typedef struct packed {
        logic [US_W-1:0]   dev_us;
        logic [NS_W-1:0]   dev_ns;   // new device time, scaled
        logic [HOST_W-1:0] host_ns;
    } t_a_stage;

    // Tracking stage contents
    typedef struct packed {
        logic [WIDE_W-1:0] mapped_ns;
        logic [WIDE_W-1:0] err_ns;
        logic [NS_W-1:0]   dev_ns;
        logic              resync;
    } t_b_stage;

    // x * 1000 = x*1024 - x*16 - x*8, no multiplier needed
    function automatic logic [NS_W-1:0] us_to_ns(input logic [US_W-1:0] x);
        logic [NS_W-1:0] xe;
        xe = {{(NS_W-US_W){1'b0}}, x};
        return (xe << 10) - (xe << 4) - (xe << 3);
    endfunction

endpackage

// ----- rtl/core/dtot_cfg.sv -----
// ============================================================================
// dtot_cfg
// Configuration registers; resync threshold and link delay are scaled to
// nanoseconds when written.
// ============================================================================
module dtot_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [dtot_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [dtot_pkg::US_W-1:0]     i_data,
    output dtot_pkg::t_cfg                o_cfg
);
    import dtot_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                CFG_HOLD_WINDOW:  n_cfg.hold_us   = i_data;
                CFG_RESYNC_THRSH: n_cfg.resync_ns = us_to_ns(i_data);
                CFG_LINK_DELAY:   n_cfg.link_ns   = us_to_ns(i_data);
                default:          n_cfg = r_cfg;   // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_us   <= HOLD_WINDOW_RST;
            r_cfg.resync_ns <= RESYNC_NS_RST;
            r_cfg.link_ns   <= LINK_NS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/dtot_track.sv -----
// ============================================================================
// dtot_track
// Hold filter and offset tracking; owns the last accepted time and the
// tracked offset.
// ============================================================================
module dtot_track (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dtot_pkg::t_a_stage  i_a,
    input  dtot_pkg::t_cfg      i_cfg,
    output dtot_pkg::t_b_stage  o_b
);
    import dtot_pkg::*;

    logic [US_W-1:0]   r_last_us;
    logic [NS_W-1:0]   r_last_ns;
    logic [WIDE_W-1:0] r_offset;
    t_b_stage          r_b;

    logic [US_W:0]     dist_us;
    logic              hold;
    logic [NS_W-1:0]   chosen_ns;
    logic [WIDE_W-1:0] host_w;
    logic [WIDE_W-1:0] host_minus_dev;
    logic [WIDE_W-1:0] err;
    logic [WIDE_W-1:0] err_mag;
    logic [WIDE_W-1:0] mapped_track;
    logic              resync;
    t_b_stage          n_b;

    always_comb begin
        // exact distance, no wrap
        dist_us = (i_a.dev_us >= r_last_us)
                ? {1'b0, i_a.dev_us} - {1'b0, r_last_us}
                : {1'b0, r_last_us} - {1'b0, i_a.dev_us};
        hold      = {1'b0, i_cfg.hold_us} > dist_us;
        chosen_ns = hold ? r_last_ns : i_a.dev_ns;

        host_w         = {1'b0, i_a.host_ns};
        host_minus_dev = host_w - {{(WIDE_W-NS_W){1'b0}}, chosen_ns};
        err            = host_minus_dev - r_offset;
        mapped_track   = {{(WIDE_W-NS_W){1'b0}}, chosen_ns} + r_offset;

        // most negative error maps to 2^63 and always resyncs
        err_mag = err[WIDE_W-1] ? (~err + 1'b1) : err;
        resync  = err_mag > {{(WIDE_W-NS_W){1'b0}}, i_cfg.resync_ns};

        n_b.mapped_ns = resync ? host_w : mapped_track;
        n_b.err_ns    = resync ? '0 : err;
        n_b.dev_ns    = chosen_ns;
        n_b.resync    = resync;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_us <= '0;
            r_last_ns <= '0;
            r_offset  <= '0;
        end else if (i_load) begin
            if (!hold) begin
                r_last_us <= i_a.dev_us;
                r_last_ns <= i_a.dev_ns;
            end
            if (resync) begin
                r_offset <= host_minus_dev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_b <= n_b;
        end
    end

    assign o_b = r_b;

endmodule

// ----- rtl/core/dtot_out.sv -----
// ============================================================================
// dtot_out
// Result register; applies the link delay correction.
// ============================================================================
module dtot_out (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  dtot_pkg::t_b_stage           i_b,
    input  logic [dtot_pkg::NS_W-1:0]    i_link_ns,
    output dtot_pkg::t_out_item          o_item
);
    import dtot_pkg::*;

    t_out_item r_item;
    t_out_item n_item;

    always_comb begin
        n_item.corrected_time_ns = i_b.mapped_ns - {{(WIDE_W-NS_W){1'b0}}, i_link_ns};
        n_item.offset_error_ns   = i_b.err_ns;
        n_item.device_time_ns    = i_b.dev_ns;
        n_item.resynced          = i_b.resync;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- rtl/core/device_timestamp_offset_tracker.sv -----
// ============================================================================
// device_timestamp_offset_tracker
// Maps 32-bit device microsecond timestamps onto the host nanosecond clock.
// ============================================================================
// One item per clock while unstalled; exactly one result per item, in order.
// There are three register stages: an input stage (scales device time to ns),
// the tracking stage (hold filter, offset add, error check, resync), and the
// result register (link delay subtract). An accepted item moves through
// them in that order, and o_out_valid is driven by the result register.
// Sustained rate is one item per cycle while the output accepts; the tracking
// stage updates its state (last accepted time, tracked offset) on the edge
// that registers its result, so a following item always sees the state left
// by the one before it. All stages hold when the output is stalled, and each
// stage can refill as its contents move on, so backpressure costs no bubbles.
// Config registers (index on i_cfg_idx): 0 hold window us, 1 resync
// threshold us (reset 100000), 2 link delay us. Other indexes are ignored.
// Write config only while no items are in flight; o_cfg_ready is always high.
// 64-bit results wrap in two's complement.
module device_timestamp_offset_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  dtot_pkg::t_in_item             i_in_data,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output dtot_pkg::t_out_item            o_out_data,

    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dtot_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtot_pkg::US_W-1:0]      i_cfg_data
);
    import dtot_pkg::*;

    t_cfg     cfg;
    t_a_stage r_a;
    t_b_stage b_stage;

    logic r_a_vld, r_b_vld, r_c_vld;
    logic n_a_vld, n_b_vld, n_c_vld;
    logic a_ready, b_ready, c_ready;
    logic a_load, b_load, c_load;

    assign o_cfg_ready = 1'b1;

    dtot_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Stage handshake: a stage takes a new item when empty or draining
    assign c_ready = !r_c_vld || i_out_ready;
    assign b_ready = !r_b_vld || c_ready;
    assign a_ready = !r_a_vld || b_ready;

    assign a_load = i_in_valid && a_ready;
    assign b_load = r_a_vld && b_ready;
    assign c_load = r_b_vld && c_ready;

    always_comb begin
        n_a_vld = a_load ? 1'b1 : (b_load ? 1'b0 : r_a_vld);
        n_b_vld = b_load ? 1'b1 : (c_load ? 1'b0 : r_b_vld);
        n_c_vld = c_load ? 1'b1 : ((r_c_vld && i_out_ready) ? 1'b0 : r_c_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= n_a_vld;
            r_b_vld <= n_b_vld;
            r_c_vld <= n_c_vld;
        end
    end

    // Input stage: scaling by 1000 is state-free, so it is done here
    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a.dev_us  <= i_in_data.device_time_us;
            r_a.dev_ns  <= us_to_ns(i_in_data.device_time_us);
            r_a.host_ns <= i_in_data.host_time_ns;
        end
    end

    dtot_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (b_load),
        .i_a     (r_a),
        .i_cfg   (cfg),
        .o_b     (b_stage)
    );

    dtot_out u_out (
        .i_clk     (i_clk),
        .i_load    (c_load),
        .i_b       (b_stage),
        .i_link_ns (cfg.link_ns),
        .o_item    (o_out_data)
    );

    assign o_in_ready  = a_ready;
    assign o_out_valid = r_c_vld;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: device timestamp offset tracker testbench
// Streams device/host timestamp pairs into the tracker and checks every
// corrected time against a cycle-free software copy of the hold filter,
// offset tracking and resync rule. Directed corners run first, then random
// phases mixing on-track timestamps with noise under changing register
// settings. Both handshakes idle and stall at random.
// ============================================================================
module tb;
    import dtot_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index, ignored
    localparam logic [63:0] NS_PER_US   = 64'd1000;
    localparam logic [63:0] HOST_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SPAN_MAX_NS = 64'd4294967295000;   // max register * 1000
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          RUN_PHASES  = 6;
    localparam int          PHASE_ITEMS = 142;

    // Expected corrected times, in acceptance order, plus the tracker state
    class corrected_time_board;
        logic [US_W-1:0] hold_us;
        logic [US_W-1:0] resync_us;
        logic [US_W-1:0] link_us;
        logic [US_W-1:0] last_us;
        logic [63:0]     offset_ns;
        t_out_item       due_q[$];
        int              mismatches;

        function new();
            hold_us    = '0;
            resync_us  = 32'd100000;
            link_us    = '0;
            last_us    = '0;
            offset_ns  = '0;
            mismatches = 0;
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [US_W-1:0] data);
            case (idx)
                CFG_HOLD_WINDOW:  hold_us   = data;
                CFG_RESYNC_THRSH: resync_us = data;
                CFG_LINK_DELAY:   link_us   = data;
                default: ;
            endcase
        endfunction

        // Hold filter: distance taken without wrap, held only strictly inside
        function logic [US_W-1:0] pick_us(logic [US_W-1:0] dev_us);
            logic [US_W-1:0] gap_us;
            gap_us = (dev_us >= last_us) ? dev_us - last_us : last_us - dev_us;
            return (hold_us > gap_us) ? last_us : dev_us;
        endfunction

        // Mapped time the next item would see, before any resync
        function logic [63:0] mapped_ns(logic [US_W-1:0] dev_us);
            return 64'(pick_us(dev_us)) * NS_PER_US + offset_ns;
        endfunction

        function void note_timestamp(t_in_item it);
            logic [US_W-1:0] chosen_us;
            logic [63:0]     dev_ns;
            logic [63:0]     host_ns;
            logic [63:0]     mapped;
            logic [63:0]     err;
            logic [63:0]     mag;
            logic            resync;
            t_out_item       r;
            chosen_us = pick_us(it.device_time_us);
            last_us   = chosen_us;
            dev_ns    = 64'(chosen_us) * NS_PER_US;
            host_ns   = {1'b0, it.host_time_ns};
            mapped    = dev_ns + offset_ns;
            err       = host_ns - mapped;
            // most negative error keeps magnitude 2^63 as unsigned
            mag       = err[63] ? -err : err;
            resync    = mag > 64'(resync_us) * NS_PER_US;
            if (resync) begin
                offset_ns = host_ns - dev_ns;
                mapped    = host_ns;
                err       = '0;
            end
            r.corrected_time_ns = mapped - 64'(link_us) * NS_PER_US;
            r.offset_error_ns   = err;
            r.device_time_ns    = dev_ns[NS_W-1:0];
            r.resynced          = resync;
            due_q.push_back(r);
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_corrected(t_out_item got);
            t_out_item want;
            if (due_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, expected none actual %h",
                         $time, got);
                return;
            end
            want = due_q.pop_front();
            field_check("corrected_time_ns", want.corrected_time_ns, got.corrected_time_ns);
            field_check("offset_error_ns", want.offset_error_ns, got.offset_error_ns);
            field_check("device_time_ns", 64'(want.device_time_ns), 64'(got.device_time_ns));
            field_check("resynced", 64'(want.resynced), 64'(got.resynced));
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_item             in_data   = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [US_W-1:0]      cfg_data  = '0;
    logic                 cfg_ready;

    corrected_time_board board;
    bit                  steady = 1'b0;   // no idling on either side while set
    int unsigned         cycles = 0;

    device_timestamp_offset_tracker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Handshake monitor: every accepted item, result and register write
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                board.note_timestamp(in_data);
            if (out_valid && out_ready)
                board.check_corrected(out_data);
            if (cfg_valid && cfg_ready)
                board.apply_register(cfg_idx, cfg_data);
        end
    end

    // Result side: a random stall ahead of every result unless steady is set
    initial begin
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic t_in_item make_item(logic [US_W-1:0] dev_us, logic [63:0] host_ns);
        t_in_item it;
        it.device_time_us = dev_us;
        it.host_time_ns   = host_ns[HOST_W-1:0];
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Host time placed a given distance from where the tracker maps dev_us
    task automatic send_track(input logic [US_W-1:0] dev_us, input longint delta);
        send_item(make_item(dev_us, board.mapped_ns(dev_us) + 64'(delta)));
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [US_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending, wait out every pending result, then idle before returning
    task automatic drain();
        in_valid <= 1'b0;
        while (board.due_q.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic random_settings();
        logic [US_W-1:0] hold;
        logic [US_W-1:0] thr;
        logic [US_W-1:0] link;
        case ($urandom_range(0, 3))
            0:       hold = '0;
            1:       hold = $urandom_range(1, 64);
            2:       hold = $urandom_range(65, 5000);
            default: hold = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       thr = '0;
            1:       thr = $urandom_range(1, 1000);
            2:       thr = 32'd100000;
            3:       thr = $urandom;
            default: thr = '1;
        endcase
        case ($urandom_range(0, 2))
            0:       link = '0;
            1:       link = $urandom;
            default: link = '1;
        endcase
        set_register(CFG_HOLD_WINDOW, hold);
        set_register(CFG_RESYNC_THRSH, thr);
        set_register(CFG_LINK_DELAY, link);
        if ($urandom_range(0, 3) == 0)
            set_register(CFG_SPARE, $urandom);
    endtask

    // Mostly on-track timestamps with jitter around the resync limit,
    // the rest raw noise
    function automatic t_in_item next_random_item();
        logic [US_W-1:0] dev_us;
        logic [63:0]     thr_ns;
        logic [63:0]     jitter;
        if ($urandom_range(0, 9) < 3)
            return make_item($urandom, {$urandom, $urandom});
        case ($urandom_range(0, 3))
            0:       dev_us = board.last_us + $urandom_range(0, 80) - 32'd40;
            1:       dev_us = board.last_us + $urandom_range(0, 5000);
            2:       dev_us = board.last_us - $urandom_range(0, 5000);
            default: dev_us = $urandom;
        endcase
        thr_ns = 64'(board.resync_us) * NS_PER_US;
        case ($urandom_range(0, 9))
            0:       jitter = '0;
            1:       jitter = thr_ns;
            2:       jitter = -thr_ns;
            3:       jitter = thr_ns + 1;
            4:       jitter = -(thr_ns + 1);
            5:       jitter = {$urandom, $urandom};
            default: begin
                jitter = {$urandom, $urandom} % (thr_ns + 1);
                if ($urandom_range(0, 1) != 0)
                    jitter = -jitter;
            end
        endcase
        return make_item(dev_us, board.mapped_ns(dev_us) + jitter);
    endfunction

    initial begin
        board = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: error at the limit, just past it, both signs
        send_item(make_item('0, '0));
        send_item(make_item('0, 64'(RESYNC_NS_RST)));
        send_item(make_item('0, 64'(RESYNC_NS_RST) + 1));
        send_item(make_item('0, 64'd1));
        send_item(make_item('0, '0));
        send_item(make_item('1, HOST_MAX));
        // offset ends at host max, so the next item lands on the most
        // negative error
        send_item(make_item('0, HOST_MAX));
        send_item(make_item(32'd1, 64'd999));
        send_track(32'd2, 0);
        drain();

        // Hold window edges, zero threshold, largest link delay (wraps)
        set_register(CFG_HOLD_WINDOW, 32'd10);
        set_register(CFG_RESYNC_THRSH, '0);
        set_register(CFG_LINK_DELAY, '1);
        send_track(32'd100, 0);
        send_track(32'd105, 0);
        send_track(32'd109, 1);
        send_track(32'd110, -1);
        send_track(32'd100, 0);
        send_track(32'd91, 0);
        drain();

        // Widest threshold and window; unmapped index must change nothing
        set_register(CFG_HOLD_WINDOW, '0);
        set_register(CFG_RESYNC_THRSH, '1);
        set_register(CFG_LINK_DELAY, $urandom);
        set_register(CFG_SPARE, '1);
        send_track('0, 0);
        drain();
        set_register(CFG_HOLD_WINDOW, '1);
        send_track('1, longint'(SPAN_MAX_NS));
        send_track(32'd5, longint'(SPAN_MAX_NS) + 1);
        send_track(32'hFFFF_FFFE, 0);
        drain();

        for (int p = 0; p < RUN_PHASES; p++) begin
            random_settings();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_item(next_random_item());
            end
            drain();
        end

        if (board.mismatches == 0 && board.due_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
